### rtl/flha_pkg.sv
// Shared word types and codes for the free-list heap allocator.
package flha_pkg;

   localparam int SIZE_W   = 10;
   localparam int OFFSET_W = 10;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_NOFIT = 1'b1;

   typedef struct packed {
      logic                func;
      logic [SIZE_W-1:0]   req_size;
      logic [OFFSET_W-1:0] free_offset;
   } req_word_type;

   typedef struct packed {
      logic                status;
      logic [OFFSET_W-1:0] payload_offset;
   } rsp_word_type;

   typedef struct packed {
      logic         strobe;
      rsp_word_type word;
   } done_type;

endpackage

### rtl/free_list_heap_allocator.sv
// Top level of the free-list heap allocator: config register, header RAM, sequencer.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+--------------------------------
//  request  | start, busy, req_word          | taken when start && !busy
//  response | rsp_strobe, rsp_word           | one-cycle strobe, no back-pressure
//  config   | csr_valid, csr_ready, csr_wdata| fit_mode written on valid && ready
//
// One request at a time. A free reads and rewrites one header; a bad offset
// is answered without a RAM access. Allocate walks the free list once, or
// twice in best-fit mode, with one header RAM read per block visited, then
// writes the taken block, the split tail if any, and the predecessor link or head.
// The result word is registered and appears in the cycle after the sequencer finishes.
// Reset: a clearing pass writes every header entry, with busy held high
// meanwhile; csr writes are taken at any time.
// The receiver cannot stall: each result word shows for exactly one cycle.
module free_list_heap_allocator
   import flha_pkg::*;
#(
   parameter int HEAP_BYTES   = 1024,
   parameter int HEADER_BYTES = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_wdata
);

   // header layout: size, free mark, next-valid, next offset
   localparam int AW = $clog2(HEAP_BYTES);
   localparam int SW = (AW > SIZE_W) ? AW : SIZE_W;
   localparam int HW = SW + 2 + AW;

   logic          fit_mode_ff, fit_mode_in;
   logic          rsp_strobe_ff;
   rsp_word_type  rsp_word_ff;

   done_type      done;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [HW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [HW-1:0] mem_rdata;

   // config channel is always open; fit_mode is sampled only when a request is taken
   assign csr_ready   = 1'b1;
   assign fit_mode_in = (csr_valid && csr_ready) ? csr_wdata : fit_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fit_mode_ff   <= fit_mode_in;
         rsp_strobe_ff <= done.strobe;
      end
   end

   // result word register, loaded only on completion
   always_ff @(posedge clock) begin
      if (done.strobe) begin
         rsp_word_ff <= done.word;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // header store: one entry per heap byte offset
   flha_ram #(
      .WIDTH (HW),
      .DEPTH (HEAP_BYTES)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   flha_ctrl #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_word  (req_word),
      .fit_mode  (fit_mode_ff),
      .busy      (busy),
      .done      (done),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

### rtl/flha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module flha_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/flha_ctrl.sv
// Sequencer: clearing pass, free-list walks, block split/unlink and free push.
module flha_ctrl
   import flha_pkg::*;
#(
   parameter int HEAP_BYTES   = 1024,
   parameter int HEADER_BYTES = 24,
   localparam int AW = $clog2(HEAP_BYTES),
   localparam int SW = (AW > SIZE_W) ? AW : SIZE_W,
   localparam int HW = SW + 2 + AW
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_word_type  req_word,
   input  logic          fit_mode,
   output logic          busy,
   output done_type      done,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output logic [HW-1:0] mem_wdata,
   output logic [AW-1:0] mem_raddr,
   input  logic [HW-1:0] mem_rdata
);

   // compare width: holds HEAP_BYTES and req + header
   localparam int CW = ((AW + 1) > (SIZE_W + 1)) ? (AW + 1) : (SIZE_W + 1);
   localparam int TW = CW + 1;   // block offset + need
   localparam int NW = AW + 1;   // walk count up to HEAP_BYTES

   typedef struct packed {
      logic [SW-1:0] size;
      logic          is_free;
      logic          has_next;
      logic [AW-1:0] next;
   } hdr_type;

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_PASS2   = 4'd2;
   localparam logic [3:0] ST_SCAN1   = 4'd3;
   localparam logic [3:0] ST_SCAN2   = 4'd4;
   localparam logic [3:0] ST_FREE    = 4'd5;
   localparam logic [3:0] ST_WR_BLK  = 4'd6;
   localparam logic [3:0] ST_WR_TAIL = 4'd7;
   localparam logic [3:0] ST_WR_LINK = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          head_valid_ff, head_valid_in;
   logic [AW-1:0] head_ff, head_in;
   logic [SW-1:0] req_ff, req_in;
   logic [CW-1:0] need_ff, need_in;
   logic [CW-1:0] bound_ff, bound_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [NW-1:0] n_ff, n_in;
   logic          has_prev_ff, has_prev_in;
   logic [AW-1:0] prev_ff, prev_in;
   hdr_type       prev_hdr_ff, prev_hdr_in;
   hdr_type       blk_hdr_ff, blk_hdr_in;
   logic          split_ff, split_in;
   logic [AW-1:0] tail_ff, tail_in;

   hdr_type       rd_hdr;
   hdr_type       init_hdr;
   hdr_type       new_blk;
   hdr_type       new_tail;
   hdr_type       link_hdr;
   logic [CW-1:0] rd_size;
   logic [NW-1:0] n_nx;
   logic          more;
   logic          fit1;
   logic          fit2;
   logic [TW-1:0] tail_w;
   logic          split_now;
   logic [TW-1:0] free_blk_w;
   logic          free_ok;
   logic [TW-1:0] pay_w;
   logic          lk_has;
   logic [AW-1:0] lk_next;
   logic [CW-1:0] tail_size_w;

   always_comb begin
      rd_hdr   = hdr_type'(mem_rdata);
      rd_size  = CW'(rd_hdr.size);
      n_nx     = n_ff + NW'(1);
      more     = rd_hdr.has_next && (n_nx < NW'(HEAP_BYTES));
      fit1     = (rd_size >= need_ff) && (rd_size <= bound_ff);
      fit2     = (rd_size >= CW'(req_ff)) && (rd_size <= bound_ff);
      tail_w   = TW'(cur_ff) + TW'(need_ff);
      split_now = (rd_size > need_ff) && (tail_w < TW'(HEAP_BYTES));

      free_blk_w = TW'(req_word.free_offset) - TW'(HEADER_BYTES);
      free_ok    = (TW'(req_word.free_offset) >= TW'(HEADER_BYTES))
                   && (free_blk_w < TW'(HEAP_BYTES));

      pay_w = TW'(cur_ff) + TW'(HEADER_BYTES);

      init_hdr.size     = SW'(HEAP_BYTES - HEADER_BYTES);
      init_hdr.is_free  = 1'b1;
      init_hdr.has_next = 1'b0;
      init_hdr.next     = '0;

      // taken block after the split decision
      new_blk = blk_hdr_ff;
      new_blk.is_free = 1'b0;
      if (split_ff) begin
         new_blk.size     = req_ff;
         new_blk.has_next = 1'b1;
         new_blk.next     = tail_ff;
      end

      tail_size_w       = CW'(blk_hdr_ff.size) - need_ff;
      new_tail.size     = tail_size_w[SW-1:0];
      new_tail.is_free  = 1'b1;
      new_tail.has_next = blk_hdr_ff.has_next;
      new_tail.next     = blk_hdr_ff.next;

      lk_has  = new_blk.has_next;
      lk_next = new_blk.next;

      // predecessor may alias the entries just written
      priority if (prev_ff == cur_ff) begin
         link_hdr = new_blk;
      end else if (split_ff && (prev_ff == tail_ff)) begin
         link_hdr = new_tail;
      end else begin
         link_hdr = prev_hdr_ff;
      end
      link_hdr.has_next = lk_has;
      link_hdr.next     = lk_next;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      req_in        = req_ff;
      need_in       = need_ff;
      bound_in      = bound_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      has_prev_in   = has_prev_ff;
      prev_in       = prev_ff;
      prev_hdr_in   = prev_hdr_ff;
      blk_hdr_in    = blk_hdr_ff;
      split_in      = split_ff;
      tail_in       = tail_ff;

      mem_we    = 1'b0;
      mem_waddr = cur_ff;
      mem_wdata = HW'(new_blk);
      mem_raddr = cur_ff;

      done.strobe              = 1'b0;
      done.word.status         = STATUS_DONE;
      done.word.payload_offset = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (clr_ff == '0) ? HW'(init_hdr) : '0;
            clr_in    = clr_ff - AW'(1);
            if (clr_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_word.func == FUNC_FREE) begin
                  if (free_ok) begin
                     cur_in    = free_blk_w[AW-1:0];
                     mem_raddr = free_blk_w[AW-1:0];
                     state_in  = ST_FREE;
                  end else begin
                     done.strobe = 1'b1;
                  end
               end else begin
                  req_in   = SW'(req_word.req_size);
                  need_in  = CW'(req_word.req_size) + CW'(HEADER_BYTES);
                  bound_in = CW'(HEAP_BYTES);
                  if (fit_mode && head_valid_ff) begin
                     mem_raddr = head_ff;
                     cur_in    = head_ff;
                     n_in      = '0;
                     state_in  = ST_SCAN1;
                  end else begin
                     state_in = ST_PASS2;
                  end
               end
            end
         end
         ST_SCAN1: begin
            if (fit1) begin
               bound_in = rd_size;
            end
            n_in = n_nx;
            if (more) begin
               mem_raddr = rd_hdr.next;
               cur_in    = rd_hdr.next;
            end else begin
               state_in = ST_PASS2;
            end
         end
         ST_PASS2: begin
            has_prev_in = 1'b0;
            n_in        = '0;
            if (head_valid_ff) begin
               mem_raddr = head_ff;
               cur_in    = head_ff;
               state_in  = ST_SCAN2;
            end else begin
               done.strobe      = 1'b1;
               done.word.status = STATUS_NOFIT;
               state_in         = ST_IDLE;
            end
         end
         ST_SCAN2: begin
            if (fit2) begin
               blk_hdr_in = rd_hdr;
               split_in   = split_now;
               tail_in    = tail_w[AW-1:0];
               state_in   = ST_WR_BLK;
            end else begin
               has_prev_in = 1'b1;
               prev_in     = cur_ff;
               prev_hdr_in = rd_hdr;
               n_in        = n_nx;
               if (more) begin
                  mem_raddr = rd_hdr.next;
                  cur_in    = rd_hdr.next;
               end else begin
                  done.strobe      = 1'b1;
                  done.word.status = STATUS_NOFIT;
                  state_in         = ST_IDLE;
               end
            end
         end
         ST_WR_BLK: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff;
            mem_wdata = HW'(new_blk);
            state_in  = split_ff ? ST_WR_TAIL : ST_WR_LINK;
         end
         ST_WR_TAIL: begin
            mem_we    = 1'b1;
            mem_waddr = tail_ff;
            mem_wdata = HW'(new_tail);
            state_in  = ST_WR_LINK;
         end
         ST_WR_LINK: begin
            if (has_prev_ff) begin
               mem_we    = 1'b1;
               mem_waddr = prev_ff;
               mem_wdata = HW'(link_hdr);
            end else begin
               head_valid_in = lk_has;
               head_in       = lk_next;
            end
            done.strobe              = 1'b1;
            done.word.payload_offset = pay_w[OFFSET_W-1:0];
            state_in                 = ST_IDLE;
         end
         ST_FREE: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff;
            mem_wdata = HW'({rd_hdr.size, 1'b1, head_valid_ff, head_ff});
            head_valid_in = 1'b1;
            head_in       = cur_ff;
            done.strobe   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= AW'(HEAP_BYTES - 1);
         head_valid_ff <= 1'b1;
         head_ff       <= '0;
         n_ff          <= '0;
         has_prev_ff   <= 1'b0;
         split_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         head_valid_ff <= head_valid_in;
         head_ff       <= head_in;
         n_ff          <= n_in;
         has_prev_ff   <= has_prev_in;
         split_ff      <= split_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      need_ff     <= need_in;
      bound_ff    <= bound_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prev_hdr_ff <= prev_hdr_in;
      blk_hdr_ff  <= blk_hdr_in;
      tail_ff     <= tail_in;
   end

   // no header writes while a walk is reading the list
   a_walk_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN1 || state_ff == ST_SCAN2) |-> !mem_we)
      else $error("header write during list walk");

   // walk length bounded by the heap size
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN1 || state_ff == ST_SCAN2) |-> (n_ff < NW'(HEAP_BYTES)))
      else $error("walk exceeded block limit");

   // tail header is written only right after a splitting block write
   a_tail_after_split: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_TAIL) |-> ($past(state_ff) == ST_WR_BLK && split_ff))
      else $error("tail write without split");

   // a no-fit result never carries an offset and returns the sequencer to idle
   a_nofit_zero: assert property (@(posedge clock) disable iff (reset)
      (done.strobe && done.word.status == STATUS_NOFIT)
         |-> (done.word.payload_offset == '0 && state_in == ST_IDLE))
      else $error("no-fit result with offset");

endmodule

### sim/tb_free_list_heap_allocator.sv
// Self-checking bench for the free-list heap allocator: heap scoreboard class and drive tasks.
import flha_pkg::*;

localparam int HEAP_BYTES   = 1024;
localparam int HEADER_BYTES = 24;

class heap_book;
   typedef struct packed {
      logic [9:0] size;
      logic       is_free;
      logic       has_next;
      logic [9:0] next;
   } header_type;

   header_type          headers [HEAP_BYTES];
   logic                head_valid;
   logic [9:0]          head;
   logic                fit_mode;
   rsp_word_type        expected_words [$];
   logic [OFFSET_W-1:0] live_offsets [$];
   int                  errors;

   function new();
      foreach (headers[i]) headers[i] = '0;
      headers[0].size    = 10'(HEAP_BYTES - HEADER_BYTES);
      headers[0].is_free = 1'b1;
      head_valid = 1'b1;
      head       = '0;
      fit_mode   = 1'b0;
      errors     = 0;
   endfunction

   function int pending();
      return expected_words.size();
   endfunction

   function rsp_word_type allocate(int req);
      rsp_word_type word;
      int           bound, need, n, b, prev, tail;
      logic         walking, has_prev;
      logic [9:0]   cur;
      word.status         = STATUS_NOFIT;
      word.payload_offset = '0;
      bound = HEAP_BYTES;
      need  = req + HEADER_BYTES;
      // best fit: the bound comes from blocks that hold req plus a header, not from req alone
      if (fit_mode) begin
         walking = head_valid;
         cur     = head;
         for (n = 0; walking && n < HEAP_BYTES; n++) begin
            if (int'(headers[cur].size) >= need && int'(headers[cur].size) <= bound)
               bound = int'(headers[cur].size);
            walking = headers[cur].has_next;
            cur     = headers[cur].next;
         end
      end
      walking  = head_valid;
      cur      = head;
      has_prev = 1'b0;
      prev     = 0;
      for (n = 0; walking && n < HEAP_BYTES; n++) begin
         b = int'(cur);
         if (int'(headers[b].size) >= req && int'(headers[b].size) <= bound) begin
            tail = b + need;
            if (int'(headers[b].size) > need && tail < HEAP_BYTES) begin
               headers[tail].size     = 10'(int'(headers[b].size) - need);
               headers[tail].is_free  = 1'b1;
               headers[tail].has_next = headers[b].has_next;
               headers[tail].next     = headers[b].next;
               headers[b].size        = 10'(req);
               headers[b].has_next    = 1'b1;
               headers[b].next        = 10'(tail);
            end
            headers[b].is_free = 1'b0;
            if (has_prev) begin
               headers[prev].has_next = headers[b].has_next;
               headers[prev].next     = headers[b].next;
            end else begin
               head_valid = headers[b].has_next;
               head       = headers[b].next;
            end
            word.status         = STATUS_DONE;
            word.payload_offset = OFFSET_W'(b + HEADER_BYTES);
            live_offsets.push_back(word.payload_offset);
            return word;
         end
         has_prev = 1'b1;
         prev     = b;
         walking  = headers[b].has_next;
         cur      = headers[b].next;
      end
      return word;
   endfunction

   function rsp_word_type free_block(int off);
      rsp_word_type word;
      int           b;
      word.status         = STATUS_DONE;
      word.payload_offset = '0;
      // no coalescing; whatever the entry holds is pushed on the list head
      if (off >= HEADER_BYTES && off - HEADER_BYTES < HEAP_BYTES) begin
         b = off - HEADER_BYTES;
         headers[b].is_free  = 1'b1;
         headers[b].has_next = head_valid;
         headers[b].next     = head;
         head_valid = 1'b1;
         head       = 10'(b);
      end
      return word;
   endfunction

   function void note_request(req_word_type w);
      if (w.func == FUNC_ALLOC)
         expected_words.push_back(allocate(int'(w.req_size)));
      else
         expected_words.push_back(free_block(int'(w.free_offset)));
   endfunction

   function void check_result(rsp_word_type got);
      rsp_word_type want;
      if (expected_words.size() == 0) begin
         $error("result word with none pending: status %0d payload_offset %0d",
                got.status, got.payload_offset);
         errors++;
      end else begin
         want = expected_words.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %0d, got %0d",
                   want.payload_offset, got.payload_offset);
            errors++;
         end
      end
   endfunction
endclass

module tb_free_list_heap_allocator;
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         start     = 1'b0;
   logic         busy;
   req_word_type req_word  = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_wdata = 1'b0;

   heap_book book = new();

   // percent of cycles in which the sender holds start low
   int idle_pct = 32;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   free_list_heap_allocator #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // Monitor. Everything here reads pre-edge values, so it sees the same
   // handshakes the RTL sees. A result is checked before a request taken on
   // the same edge is predicted; the queue is FIFO, so order only matters for
   // the unexpected-word case.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            book.check_result(rsp_word);
         if (start && !busy)
            book.note_request(req_word);
         if (csr_valid && csr_ready)
            book.fit_mode = csr_wdata;
      end
   end

   // Unused field of each word gets random bits so every input bit toggles.
   function automatic req_word_type make_word(logic f, int value);
      req_word_type w;
      w.func        = f;
      w.req_size    = SIZE_W'($urandom);
      w.free_offset = OFFSET_W'($urandom);
      if (f == FUNC_ALLOC)
         w.req_size = SIZE_W'(value);
      else
         w.free_offset = OFFSET_W'(value);
      return w;
   endfunction

   // Mostly well-formed traffic: allocations of small sizes and frees of
   // offsets that were handed out. The rest are stray frees that hit bad
   // offsets, never-written headers and now and then a block already free.
   function automatic req_word_type random_word();
      int                  pick, idx;
      logic [OFFSET_W-1:0] off;
      pick = $urandom_range(99);
      if (pick < 55)
         return make_word(FUNC_ALLOC, ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                                : $urandom_range(80));
      if (pick < 92 && book.live_offsets.size() != 0) begin
         idx = $urandom_range(book.live_offsets.size() - 1);
         off = book.live_offsets[idx];
         book.live_offsets.delete(idx);
         return make_word(FUNC_FREE, int'(off));
      end
      return make_word(FUNC_FREE, $urandom_range(1023));
   endfunction

   // Present one word; start drops at random cycles, including while busy.
   // Returns on the edge that took the word, so start is updated exactly
   // once in that step by whatever comes next.
   task automatic issue(req_word_type w);
      logic taken;
      req_word <= w;
      taken = 1'b0;
      while (!taken) begin
         start <= ($urandom_range(99) >= idle_pct);
         @(posedge clock);
         taken = start && !busy;
      end
   endtask

   // Hold off until every predicted word has come back.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   task automatic write_fit_mode(logic mode);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int phase, k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // first fit: splits, exact fit, no fit, bad and never-written frees
      write_fit_mode(1'b0);
      issue(make_word(FUNC_ALLOC, 0));
      issue(make_word(FUNC_ALLOC, 100));
      issue(make_word(FUNC_ALLOC, 1023));
      issue(make_word(FUNC_FREE, 0));
      issue(make_word(FUNC_FREE, HEADER_BYTES - 1));
      issue(make_word(FUNC_FREE, 1023));
      issue(make_word(FUNC_ALLOC, 0));
      issue(make_word(FUNC_FREE, 48));
      issue(make_word(FUNC_ALLOC, 100));
      issue(make_word(FUNC_FREE, 48));
      issue(make_word(FUNC_ALLOC, 60));
      issue(make_word(FUNC_ALLOC, 10));
      issue(make_word(FUNC_ALLOC, 1023));

      // best fit: bound from splittable blocks, no block past the bound
      write_fit_mode(1'b1);
      issue(make_word(FUNC_FREE, 1023));
      issue(make_word(FUNC_FREE, 48));
      issue(make_word(FUNC_ALLOC, 5));
      issue(make_word(FUNC_ALLOC, 200));
      issue(make_word(FUNC_ALLOC, 30));
      issue(make_word(FUNC_ALLOC, 900));
      issue(make_word(FUNC_ALLOC, 1023));
      issue(make_word(FUNC_ALLOC, 0));

      // random phases alternate the mode; phase 2 runs with no sender idles
      for (phase = 0; phase < 4; phase++) begin
         write_fit_mode(phase % 2 == 1);
         idle_pct = (phase == 2) ? 0 : 32;
         for (k = 0; k < 105; k++) begin
            if ($urandom_range(63) == 0)
               drain();
            issue(random_word());
         end
      end
      idle_pct = 32;

      // double free last: the self-loop it leaves makes every later walk
      // run to the block cap, so keep it to the tail of the run
      write_fit_mode(1'b0);
      issue(make_word(FUNC_FREE, 48));
      issue(make_word(FUNC_FREE, 48));
      issue(make_word(FUNC_ALLOC, 1023));
      issue(make_word(FUNC_ALLOC, 0));
      write_fit_mode(1'b1);
      issue(make_word(FUNC_ALLOC, 1023));
      issue(make_word(FUNC_ALLOC, 3));

      drain();
      // keep clocking after the drain to catch a stray word
      repeat (2200) @(posedge clock);
      if (book.errors == 0 && book.pending() == 0)
         $display("free_list_heap_allocator: match");
      else
         $display("free_list_heap_allocator: mismatch");
      $finish;
   end

   // Worst case is every item doing two capped walks; this is several times that.
   initial begin : watchdog
      #50_000_000;
      $display("free_list_heap_allocator: mismatch");
      $finish;
   end
endmodule
